// ===== rtl/bsoc_pkg.sv =====
// bsoc_pkg: shared types, sizes and codes for the charge lookup block.
// No dependencies.
package bsoc_pkg;

    localparam int VOLTAGE_POINTS     = 5;
    localparam int TEMPERATURE_POINTS = 4;
    localparam int VI_W  = $clog2(VOLTAGE_POINTS);
    localparam int TI_W  = $clog2(TEMPERATURE_POINTS);
    localparam int TBL_N = VOLTAGE_POINTS * TEMPERATURE_POINTS;
    localparam int TBL_W = $clog2(TBL_N);
    localparam logic [14:0] FULL_CHARGE = 15'd25600;

    typedef enum logic [1:0] {
        t_ACT_COMPUTE = 2'd0,
        t_ACT_LOAD_V  = 2'd1,
        t_ACT_LOAD_T  = 2'd2,
        t_ACT_LOAD_C  = 2'd3
    } t_action;

    localparam logic [1:0] REG_RES = 2'd0;
    localparam logic [1:0] REG_LOW = 2'd1;
    localparam logic [1:0] REG_HIGH = 2'd2;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_MUL,
        t_ST_SCAN,
        t_ST_DIV,
        t_ST_BLEND,
        t_ST_OUT
    } t_state;

endpackage

// ===== rtl/battery_soc_bilinear_lookup.sv =====
// battery_soc_bilinear_lookup: top level, control sequencer and stores.
// Depends on bsoc_pkg and bsoc_divider.
//
// Usage: input words arrive on i_valid/o_ready with action and operands;
// load words fill breakpoints and the charge table and give no result.
// A compute word runs a sequence: a shift-add multiply of current by
// series resistance, an interval scan over the breakpoints (one interval
// per cycle), two restoring divisions in a shared divider, and four
// shift-add weight products. If Voc is at or below the low limit or at or
// above the high limit, the sequence goes from the multiply straight to
// the output with 0 or full charge. No new word is taken while a
// sequence runs.
// The result word sits in an output register on o_valid/i_ready; the block
// takes a new word only once it is taken, so a stalled receiver holds the input.
// Reset restores the configuration registers to 512, 200 and 400; the
// stores are left undefined and must be loaded before use.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data.
module battery_soc_bilinear_lookup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_row_index,
    input  logic [2:0]  i_column_index,
    input  logic signed [9:0]  i_load_value,
    input  logic [14:0] i_pack_voltage,
    input  logic signed [15:0] i_pack_current,
    input  logic signed [11:0] i_cell_temperature,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [14:0] o_state_of_charge
);
    localparam int VP = bsoc_pkg::VOLTAGE_POINTS;
    localparam int TP = bsoc_pkg::TEMPERATURE_POINTS;

    logic [11:0] r_res;
    logic [8:0]  r_low, r_high;
    logic [8:0]  r_vbp [VP];
    logic signed [7:0] r_tbp [TP];
    logic [6:0]  r_tbl [bsoc_pkg::TBL_N];

    bsoc_pkg::t_state r_st, n_st;
    logic signed [33:0] r_voc;      // 2^-16 V
    logic signed [11:0] r_temp;
    logic [15:0] r_cur;             // current multiplier, shifted out
    logic [4:0]  r_cnt;
    logic [3:0]  r_scan;
    logic [bsoc_pkg::VI_W-1:0] r_vi;
    logic [bsoc_pkg::TI_W-1:0] r_ti;
    logic [16:0] r_vf, r_tf;
    logic        r_phase;           // 0 voltage divide, 1 temperature
    logic [1:0]  r_corner;
    logic [49:0] r_acc;             // sum in 2^-32 percent
    logic [33:0] r_w;               // weight product being formed
    logic [16:0] r_mb;              // multiplier bits, shifted out
    logic [14:0] r_soc;
    logic        r_ovalid;

    // cfg
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= 12'd512; r_low <= 9'd200; r_high <= 9'd400;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bsoc_pkg::REG_RES:  r_res  <= i_cfg_data;
                bsoc_pkg::REG_LOW:  r_low  <= i_cfg_data[8:0];
                bsoc_pkg::REG_HIGH: r_high <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    logic w_acc_in;
    assign o_ready  = (r_st == bsoc_pkg::t_ST_IDLE) && !r_ovalid;
    assign w_acc_in = i_valid && o_ready;

    // stores
    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            case (bsoc_pkg::t_action'(i_action))
                bsoc_pkg::t_ACT_LOAD_V:
                    if (32'(i_column_index) < VP)
                        r_vbp[i_column_index[bsoc_pkg::VI_W-1:0]] <= i_load_value[8:0];
                bsoc_pkg::t_ACT_LOAD_T:
                    if (32'(i_row_index) < TP)
                        r_tbp[i_row_index[bsoc_pkg::TI_W-1:0]] <= i_load_value[7:0];
                bsoc_pkg::t_ACT_LOAD_C:
                    if (32'(i_row_index) < TP && 32'(i_column_index) < VP)
                        r_tbl[bsoc_pkg::TBL_W'(32'(i_row_index) * VP + 32'(i_column_index))]
                            <= i_load_value[6:0];
                default: ;
            endcase
        end
    end

    // scan step: one interval of each axis per cycle
    logic signed [33:0] w_va, w_vb;
    logic signed [15:0] w_ta, w_tb;
    logic w_vhit, w_thit, w_vok, w_tok;
    logic [bsoc_pkg::VI_W-1:0] w_vidx;
    logic [bsoc_pkg::TI_W-1:0] w_tidx;
    always_comb begin
        w_vok = 32'(r_scan) + 1 < VP;
        w_tok = 32'(r_scan) + 1 < TP;
        w_vidx = w_vok ? r_scan[bsoc_pkg::VI_W-1:0] : '0;
        w_tidx = w_tok ? r_scan[bsoc_pkg::TI_W-1:0] : '0;
        w_va = {9'd0, r_vbp[w_vidx], 16'd0};
        w_vb = {9'd0, r_vbp[w_vidx + 1'b1], 16'd0};
        w_ta = {{4{r_tbp[w_tidx][7]}}, r_tbp[w_tidx], 4'd0};
        w_tb = {{4{r_tbp[w_tidx + 1'b1][7]}}, r_tbp[w_tidx + 1'b1], 4'd0};
        w_vhit = w_vok && r_voc > w_va && r_voc <= w_vb;
        w_thit = w_tok && 16'(r_temp) > w_ta && 16'(r_temp) <= w_tb;
    end
    logic r_vfound, r_tfound;

    // divider
    logic        w_dstart, w_ddone;
    logic [40:0] w_dnum;
    logic [17:0] w_dden;
    logic [16:0] w_dq;
    logic signed [33:0] w_vdiff;
    logic signed [15:0] w_tdiff;
    always_comb begin
        w_vdiff = r_voc - {9'd0, r_vbp[r_vi], 16'd0};
        w_tdiff = 16'(r_temp) - {{4{r_tbp[r_ti][7]}}, r_tbp[r_ti], 4'd0};
        // the temperature operands are needed from the cycle the first quotient lands
        if (!r_phase && !w_ddone) begin
            w_dnum = {7'd0, w_vdiff};
            w_dden = {9'd0, r_vbp[r_vi + 1'b1] - r_vbp[r_vi]};
        end else begin
            w_dnum = {13'd0, w_tdiff[15:0], 12'd0};
            w_dden = {10'd0, 8'(r_tbp[r_ti + 1'b1] - r_tbp[r_ti])};
        end
    end

    bsoc_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_done(w_ddone), .o_quot(w_dq)
    );

    // corner selection
    logic [bsoc_pkg::TBL_W-1:0] w_cidx;
    logic [16:0] w_fa, w_fb;
    always_comb begin
        w_cidx = bsoc_pkg::TBL_W'((32'(r_ti) + 32'(r_corner[1])) * VP
                 + 32'(r_vi) + 32'(r_corner[0]));
        w_fa = r_corner[0] ? r_vf : 17'(18'h10000 - 18'(r_vf));
        w_fb = r_corner[1] ? r_tf : 17'(18'h10000 - 18'(r_tf));
    end

    logic signed [33:0] w_voc0, w_lo, w_hi;
    always_comb begin
        w_voc0 = 34'(i_pack_voltage) <<< 10;
        w_lo = {9'd0, r_low, 16'd0};
        w_hi = {9'd0, r_high, 16'd0};
    end

    logic [49:0] w_round;
    assign w_round = (r_acc + 50'(1 << 23)) >> 24;

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            bsoc_pkg::t_ST_IDLE:
                if (w_acc_in && i_action == bsoc_pkg::t_ACT_COMPUTE) n_st = bsoc_pkg::t_ST_MUL;
            bsoc_pkg::t_ST_MUL:
                if (r_cnt == 5'd16) begin
                    if (r_voc <= w_lo || r_voc >= w_hi) n_st = bsoc_pkg::t_ST_OUT;
                    else n_st = bsoc_pkg::t_ST_SCAN;
                end
            bsoc_pkg::t_ST_SCAN:
                if (r_scan == 4'd7) n_st = bsoc_pkg::t_ST_DIV;
            bsoc_pkg::t_ST_DIV:
                if (w_ddone && r_phase) n_st = bsoc_pkg::t_ST_BLEND;
            bsoc_pkg::t_ST_BLEND:
                if (r_corner == 2'd3 && r_cnt == 5'd18) n_st = bsoc_pkg::t_ST_OUT;
            bsoc_pkg::t_ST_OUT: n_st = bsoc_pkg::t_ST_IDLE;
            default: n_st = bsoc_pkg::t_ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    assign w_dstart = (r_st == bsoc_pkg::t_ST_SCAN && r_scan == 4'd7)
                   || (r_st == bsoc_pkg::t_ST_DIV && w_ddone && !r_phase);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= bsoc_pkg::t_ST_IDLE; r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (r_st == bsoc_pkg::t_ST_OUT) r_ovalid <= 1'b1;
        end
        case (r_st)
            bsoc_pkg::t_ST_IDLE: begin
                r_voc <= w_voc0; r_temp <= i_cell_temperature;
                r_cur <= i_pack_current;
                r_cnt <= '0;
            end
            bsoc_pkg::t_ST_MUL: begin
                // one multiplier bit per cycle; the sign bit weighs negative
                if (r_cnt != 5'd16) begin
                    if (r_cur[0]) begin
                        if (r_cnt == 5'd15)
                            r_voc <= r_voc - (34'(r_res) << r_cnt);
                        else
                            r_voc <= r_voc + (34'(r_res) << r_cnt);
                    end
                    r_cur <= r_cur >> 1;
                    r_cnt <= r_cnt + 5'd1;
                end
                r_scan <= '0; r_vi <= '0; r_ti <= '0;
                r_vfound <= 1'b0; r_tfound <= 1'b0;
                r_vf <= '0; r_tf <= '0; r_phase <= 1'b0;
            end
            bsoc_pkg::t_ST_SCAN: begin
                if (w_vhit && !r_vfound) begin r_vi <= w_vidx; r_vfound <= 1'b1; end
                if (w_thit && !r_tfound) begin r_ti <= w_tidx; r_tfound <= 1'b1; end
                r_scan <= r_scan + 4'd1;
            end
            bsoc_pkg::t_ST_DIV: begin
                if (w_ddone) begin
                    if (!r_phase) r_vf <= r_vfound ? w_dq : 17'd0;
                    else r_tf <= r_tfound ? w_dq : 17'd0;
                    r_phase <= 1'b1;
                end
                r_corner <= '0; r_cnt <= '0; r_acc <= '0;
            end
            bsoc_pkg::t_ST_BLEND: begin
                // weight fa*fb by shift-add over all 17 bits, then scale by the table entry
                if (r_cnt == 5'd0) begin
                    r_w <= '0; r_mb <= w_fb; r_cnt <= 5'd1;
                end else if (r_cnt != 5'd18) begin
                    if (r_mb[0]) r_w <= r_w + (34'(w_fa) << (r_cnt - 5'd1));
                    r_mb <= r_mb >> 1;
                    r_cnt <= r_cnt + 5'd1;
                end else begin
                    r_acc <= r_acc + 50'(r_w) * 50'(r_tbl[w_cidx]);
                    r_corner <= r_corner + 2'd1;
                    r_cnt <= '0;
                end
            end
            bsoc_pkg::t_ST_OUT: begin
                if (r_voc <= w_lo) r_soc <= '0;
                else if (r_voc >= w_hi) r_soc <= bsoc_pkg::FULL_CHARGE;
                else if (w_round > 50'(bsoc_pkg::FULL_CHARGE)) r_soc <= bsoc_pkg::FULL_CHARGE;
                else r_soc <= w_round[14:0];
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_state_of_charge = r_soc;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != bsoc_pkg::t_ST_IDLE |-> !o_ready)
        else $error("word accepted while busy");
    a_soc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_state_of_charge <= bsoc_pkg::FULL_CHARGE)
        else $error("charge above full");
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_st) == bsoc_pkg::t_ST_OUT)
        else $error("result without sequence");
`endif
endmodule

// ===== rtl/bsoc_divider.sv =====
// bsoc_divider: restoring divider, one quotient bit per cycle.
// No dependencies.
module bsoc_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [40:0] i_num,
    input  logic [17:0] i_den,
    output logic        o_done,
    output logic [16:0] o_quot
);
    logic [40:0] r_num, n_num;
    logic [17:0] r_rem, n_rem;
    logic [16:0] r_q, n_q;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [18:0] w_trial;

    always_comb begin
        n_num = r_num; n_rem = r_rem; n_q = r_q; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        w_trial = {r_rem, r_num[40]} - {1'b0, i_den};
        if (i_start) begin
            n_num = i_num; n_rem = '0; n_q = '0; n_cnt = 6'd41; n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[39:0], 1'b0};
            if (!w_trial[18]) begin
                n_rem = w_trial[17:0];
                n_q   = {r_q[15:0], 1'b1};
            end else begin
                n_rem = {r_rem[16:0], r_num[40]};
                n_q   = {r_q[15:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_num <= n_num; r_rem <= n_rem; r_q <= n_q;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== bench/testbench.sv =====
// Testbench for battery_soc_bilinear_lookup: directed and random charge lookups,
// checked word by word against a predictor of the fixed-point bilinear estimate.
// Depends on bsoc_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [11:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_action;
    logic [2:0]  i_row_index;
    logic [2:0]  i_column_index;
    logic signed [9:0]  i_load_value;
    logic [14:0] i_pack_voltage;
    logic signed [15:0] i_pack_current;
    logic signed [11:0] i_cell_temperature;
    logic        o_valid;
    logic        i_ready;
    logic [14:0] o_state_of_charge;

    battery_soc_bilinear_lookup u_top (.*);

    // predictor copy of registers and stores
    logic [11:0] res_ohm;
    logic [8:0]  low_volts;
    logic [8:0]  high_volts;
    logic [8:0]  volt_pts [bsoc_pkg::VOLTAGE_POINTS];
    logic signed [7:0] temp_pts [bsoc_pkg::TEMPERATURE_POINTS];
    logic [6:0]  charge_map [bsoc_pkg::TBL_N];

    logic [14:0] soc_expected [$];
    int          error_count;
    int          compute_count;
    int          load_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("[battery_soc_bilinear_lookup] ERROR");
        $finish;
    end

    always @(negedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (soc_expected.size() == 0) begin
                $display("%t: unexpected charge word %0d", $time, o_state_of_charge);
                error_count++;
            end else begin
                if (o_state_of_charge !== soc_expected[0]) begin
                    $display("%t: charge mismatch, expected %0d, got %0d", $time,
                             soc_expected[0], o_state_of_charge);
                    error_count++;
                end
                void'(soc_expected.pop_front());
            end
        end
    end

    // first interval a < x <= b, fraction as Q16; index 0 and fraction 0 if none
    function automatic int find_span(longint x, longint pts[8], int n, int sc, int fs,
                                     output longint frac);
        longint a;
        longint b;
        frac = 0;
        for (int i = 0; i + 1 < n; i++) begin
            a = pts[i] <<< sc;
            b = pts[i + 1] <<< sc;
            if (x > a && x <= b) begin
                frac = ((x - a) <<< fs) / (pts[i + 1] - pts[i]);
                return i;
            end
        end
        return 0;
    endfunction

    function automatic logic [14:0] soc_estimate(logic [14:0] pv, logic signed [15:0] cur,
                                                 logic signed [11:0] tmp);
        longint voc;
        longint vp [8];
        longint tp [8];
        longint vf;
        longint tf;
        int vi;
        int ti;
        longint unsigned total;
        longint unsigned soc;
        voc = longint'(pv) * 1024 + longint'(cur) * longint'(res_ohm);
        if (voc <= longint'(low_volts) * 65536) return 15'd0;
        if (voc >= longint'(high_volts) * 65536) return bsoc_pkg::FULL_CHARGE;
        foreach (vp[i])
            vp[i] = (i < bsoc_pkg::VOLTAGE_POINTS) ? longint'(volt_pts[i]) : 0;
        foreach (tp[i])
            tp[i] = (i < bsoc_pkg::TEMPERATURE_POINTS) ? longint'(temp_pts[i]) : 0;
        vi = find_span(voc, vp, bsoc_pkg::VOLTAGE_POINTS, 16, 0, vf);
        ti = find_span(longint'(tmp), tp, bsoc_pkg::TEMPERATURE_POINTS, 4, 12, tf);
        total = longint'(charge_map[ti * bsoc_pkg::VOLTAGE_POINTS + vi])
                  * (65536 - vf) * (65536 - tf)
              + longint'(charge_map[ti * bsoc_pkg::VOLTAGE_POINTS + vi + 1])
                  * vf * (65536 - tf)
              + longint'(charge_map[(ti + 1) * bsoc_pkg::VOLTAGE_POINTS + vi])
                  * (65536 - vf) * tf
              + longint'(charge_map[(ti + 1) * bsoc_pkg::VOLTAGE_POINTS + vi + 1])
                  * vf * tf;
        soc = (total + (64'd1 << 23)) >> 24;
        if (soc > bsoc_pkg::FULL_CHARGE) soc = bsoc_pkg::FULL_CHARGE;
        return soc[14:0];
    endfunction

    task automatic send_word(bsoc_pkg::t_action act, logic [2:0] row, logic [2:0] col,
                             logic signed [9:0] lv, logic [14:0] pv,
                             logic signed [15:0] cur, logic signed [11:0] tmp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_action = act;
        i_row_index = row;
        i_column_index = col;
        i_load_value = lv;
        i_pack_voltage = pv;
        i_pack_current = cur;
        i_cell_temperature = tmp;
        do @(posedge i_clk); while (!o_ready);
        case (act)
            bsoc_pkg::t_ACT_COMPUTE: begin
                soc_expected.push_back(soc_estimate(pv, cur, tmp));
                compute_count++;
            end
            bsoc_pkg::t_ACT_LOAD_V: begin
                if (col < bsoc_pkg::VOLTAGE_POINTS) volt_pts[col] = lv[8:0];
                load_count++;
            end
            bsoc_pkg::t_ACT_LOAD_T: begin
                if (row < bsoc_pkg::TEMPERATURE_POINTS) temp_pts[row] = lv[7:0];
                load_count++;
            end
            default: begin
                if (row < bsoc_pkg::TEMPERATURE_POINTS && col < bsoc_pkg::VOLTAGE_POINTS)
                    charge_map[row * bsoc_pkg::VOLTAGE_POINTS + col] = lv[6:0];
                load_count++;
            end
        endcase
        @(negedge i_clk);
    endtask

    task automatic send_load(bsoc_pkg::t_action act, int row, int col, int lv);
        send_word(act, row[2:0], col[2:0], lv[9:0], 15'($urandom), 16'($urandom),
                  12'($urandom));
    endtask

    task automatic send_compute(int pv, int cur, int tmp);
        send_word(bsoc_pkg::t_ACT_COMPUTE, 3'($urandom), 3'($urandom), 10'($urandom),
                  pv[14:0], cur[15:0], tmp[11:0]);
    endtask

    // hold until every word is back, then give the block time to settle
    task automatic drain_results();
        i_valid = 1'b0;
        while (soc_expected.size() != 0) @(negedge i_clk);
        repeat (250) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value[11:0];
        case (idx)
            bsoc_pkg::REG_RES:  res_ohm = value[11:0];
            bsoc_pkg::REG_LOW:  low_volts = value[8:0];
            default:  high_volts = value[8:0];
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_limits(int r, int lo, int hi);
        drain_results();
        write_reg(bsoc_pkg::REG_RES, r);
        write_reg(bsoc_pkg::REG_LOW, lo);
        write_reg(bsoc_pkg::REG_HIGH, hi);
    endtask

    task automatic fill_stores();
        int vb [bsoc_pkg::VOLTAGE_POINTS] = '{210, 250, 300, 350, 390};
        int tb [bsoc_pkg::TEMPERATURE_POINTS] = '{-20, 0, 25, 60};
        for (int c = 0; c < bsoc_pkg::VOLTAGE_POINTS; c++)
            send_load(bsoc_pkg::t_ACT_LOAD_V, 0, c, vb[c]);
        for (int r = 0; r < bsoc_pkg::TEMPERATURE_POINTS; r++)
            send_load(bsoc_pkg::t_ACT_LOAD_T, r, 0, tb[r]);
        for (int r = 0; r < bsoc_pkg::TEMPERATURE_POINTS; r++)
            for (int c = 0; c < bsoc_pkg::VOLTAGE_POINTS; c++)
                send_load(bsoc_pkg::t_ACT_LOAD_C, r, c, 10 + 7 * r + 9 * c);
        // extremes of the load value: -512 stores 0, -1 stores 127
        send_load(bsoc_pkg::t_ACT_LOAD_C, 0, 0, -512);
        send_load(bsoc_pkg::t_ACT_LOAD_C, 1, 1, -1);
    endtask

    task automatic test_directed();
        set_limits(512, 200, 400);
        fill_stores();
        // out-of-range load indexes must be dropped
        send_load(bsoc_pkg::t_ACT_LOAD_V, 7, 7, 511);
        send_load(bsoc_pkg::t_ACT_LOAD_T, 7, 7, 511);
        send_load(bsoc_pkg::t_ACT_LOAD_C, 4, 5, 100);
        send_compute(0, -32768, 0);
        send_compute(32767, 32767, 0);
        send_compute(200 * 64, 0, 0);
        send_compute(400 * 64, 0, 0);
        send_compute(275 * 64 + 17, 0, 100);
        send_compute(320 * 64, -600, -2048);
        send_compute(320 * 64, 600, 2047);
        send_compute(250 * 64, 0, 0);
        send_compute(230 * 64, 0, -20 * 16);
        send_compute(210 * 64, 0, 60 * 16);
        send_compute(205 * 64, 0, 5);
        // Voc between the limits but below the lowest breakpoint, then Voc above the high limit
        set_limits(0, 0, 511);
        send_compute(64, 0, 0);
        send_compute(32767, 0, 0);
        // crossed limits: the low test wins
        set_limits(512, 300, 250);
        send_compute(280 * 64, 0, 0);
        send_compute(500 * 64, 0, 0);
    endtask

    task automatic send_targeted();
        longint tgt;
        longint cur;
        longint pv;
        int tmp;
        int lo;
        int hi;
        lo = (low_volts < high_volts) ? low_volts : 0;
        hi = (low_volts < high_volts) ? high_volts : 511;
        tgt = longint'($urandom_range(hi, lo)) * 65536 + $urandom_range(65535);
        cur = ($urandom_range(2) == 0) ? 0 : longint'($signed($urandom_range(65535) - 32768));
        pv = (tgt - cur * res_ohm) / 1024;
        if (pv < 0 || pv > 32767) begin
            cur = 0;
            pv = tgt / 1024;
        end
        if ($urandom_range(9) < 8 && temp_pts[3] > temp_pts[0])
            tmp = int'(temp_pts[0]) * 16 - 4
                + $urandom_range((int'(temp_pts[3]) - int'(temp_pts[0])) * 16 + 8);
        else
            tmp = $urandom_range(4095) - 2048;
        send_compute(int'(pv), int'(cur), tmp);
    endtask

    task automatic test_random(int count);
        int pick;
        for (int k = 0; k < count; k++) begin
            case (k * 4 / count)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            pick = $urandom_range(99);
            if (pick < 12)
                send_load(bsoc_pkg::t_action'($urandom_range(3, 1)), $urandom_range(7),
                          $urandom_range(7), $urandom_range(1023) - 512);
            else if (pick < 27)
                send_compute($urandom_range(32767), $urandom_range(65535) - 32768,
                             $urandom_range(4095) - 2048);
            else
                send_targeted();
        end
    endtask

    initial begin
        static int phases [5][3] = '{'{512, 200, 400}, '{0, 0, 511}, '{4095, 220, 380},
                                     '{100, 511, 0}, '{1800, 205, 395}};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = bsoc_pkg::REG_RES;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_action = bsoc_pkg::t_ACT_COMPUTE;
        i_row_index = '0;
        i_column_index = '0;
        i_load_value = '0;
        i_pack_voltage = '0;
        i_pack_current = '0;
        i_cell_temperature = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        compute_count = 0;
        load_count = 0;
        res_ohm = 12'd512;
        low_volts = 9'd200;
        high_volts = 9'd400;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        foreach (phases[p]) begin
            set_limits(phases[p][0], phases[p][1], phases[p][2]);
            test_random(70);
        end

        drain_results();
        $display("Covered %0d charge computations and %0d store loads over 8 register settings,",
                 compute_count, load_count);
        $display("with sender gaps and receiver stalls in turn; %0d mismatches.", error_count);
        if (error_count == 0)
            $display("[battery_soc_bilinear_lookup] OK");
        else
            $display("[battery_soc_bilinear_lookup] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bsoc_pkg.sv
rtl/bsoc_divider.sv
rtl/battery_soc_bilinear_lookup.sv
bench/testbench.sv
